[rtl/gcsp_pkg.sv]
package gcsp_pkg;

    // Item kinds carried in the input tuser field.
    typedef enum logic [2:0] {
        CMD_DATA_WR   = 3'd0,
        CMD_CTRL_WR   = 3'd1,
        CMD_STATUS_RD = 3'd2,
        CMD_DATA_RD   = 3'd3,
        CMD_VBLANK    = 3'd4
    } cmd_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd5;

    // Control port opcodes (top byte of the control word).
    localparam logic [7:0] CTL_RESET      = 8'h00;
    localparam logic [7:0] CTL_ABORT_A    = 8'h01;
    localparam logic [7:0] CTL_ABORT_B    = 8'h02;
    localparam logic [7:0] CTL_DISP_EN    = 8'h03;
    localparam logic [7:0] CTL_DMA_DIR    = 8'h04;
    localparam logic [7:0] CTL_DISP_START = 8'h05;
    localparam logic [7:0] CTL_HRANGE     = 8'h06;
    localparam logic [7:0] CTL_VRANGE     = 8'h07;
    localparam logic [7:0] CTL_MODE       = 8'h08;
    localparam logic [7:0] CTL_BUS        = 8'h09;
    localparam logic [7:0] CTL_INFO       = 8'h10;

    // Info query selectors.
    localparam logic [15:0] INFO_AREA_A  = 16'd0;
    localparam logic [15:0] INFO_AREA_B  = 16'd1;
    localparam logic [15:0] INFO_AREA_C  = 16'd3;
    localparam logic [15:0] INFO_AREA_END = 16'd4;
    localparam logic [15:0] INFO_OFFS_A  = 16'd5;
    localparam logic [15:0] INFO_OFFS_B  = 16'd6;
    localparam logic [15:0] INFO_VERSION = 16'd7;
    localparam logic [31:0] INFO_VERSION_VAL = 32'd2;

    // Status word constants.
    localparam logic [31:0] ST_RESET     = 32'h1480_2000;
    localparam logic [31:0] ST_DMA_READY = 32'h0800_0000;
    localparam logic [31:0] ST_IDLE_BITS = 32'h1400_0000;
    localparam logic [31:0] DMA_OFF_WORD = 32'h0400_0000;
    localparam logic [31:0] ST_MODE_MASK = 32'h007F_0000;
    localparam logic [31:0] ST_DMA_DIR   = 32'h6000_0000;
    localparam logic [31:0] ST_FIELD     = 32'h8000_0000;
    localparam logic [31:0] ST_DISP_OFF  = 32'h0080_0000;

    // Drawing area bounds restored by a control reset.
    localparam logic [10:0] DRAW_RIGHT_RST  = 11'd256;
    localparam logic [9:0]  DRAW_BOTTOM_RST = 10'd240;

    // One input beat.
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] word;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] read_value;
        logic [31:0] packet_word;
        logic [3:0]  packet_slot;
        logic        packet_valid;
        logic        packet_done;
        logic [9:0]  display_x;
        logic [9:0]  display_y;
        logic [9:0]  display_width;
        logic [8:0]  display_height;
    } result_t;

    // Number of words that follow a packet header, by its top byte.
    function automatic logic [3:0] word_count(input logic [7:0] op);
        logic [3:0] cnt;
        case (op) inside
            8'h02:                                     cnt = 4'd2;
            [8'h20:8'h23], [8'h48:8'h53], [8'h64:8'h67],
            8'h80:                                     cnt = 4'd3;
            [8'h24:8'h27]:                             cnt = 4'd6;
            [8'h28:8'h2B], [8'h58:8'h5F]:              cnt = 4'd4;
            [8'h2C:8'h2F], [8'h34:8'h37]:              cnt = 4'd8;
            [8'h30:8'h33]:                             cnt = 4'd5;
            [8'h38:8'h3B]:                             cnt = 4'd7;
            [8'h3C:8'h3F]:                             cnt = 4'd11;
            [8'h40:8'h43], [8'h60:8'h63], [8'h6C:8'h6F],
            [8'h74:8'h77], [8'h7C:8'h7F], 8'hA0, 8'hC0: cnt = 4'd2;
            [8'h68:8'h6B], [8'h70:8'h73], [8'h78:8'h7B]: cnt = 4'd1;
            default:                                   cnt = 4'd0;
        endcase
        return cnt;
    endfunction

    // Horizontal resolution from status bits 16..18.
    function automatic logic [9:0] width_lut(input logic [2:0] idx);
        logic [9:0] w;
        case (idx)
            3'd0:    w = 10'd256;
            3'd1:    w = 10'd368;
            3'd2:    w = 10'd320;
            3'd3:    w = 10'd384;
            3'd4:    w = 10'd512;
            3'd5:    w = 10'd512;
            default: w = 10'd640;
        endcase
        return w;
    endfunction

    // Vertical resolution from status bits 19..20.
    function automatic logic [8:0] height_lut(input logic [1:0] idx);
        logic [8:0] h;
        case (idx)
            2'd0:    h = 9'd240;
            2'd2:    h = 9'd256;
            default: h = 9'd480;
        endcase
        return h;
    endfunction

endpackage

[rtl/gcsp_in_stage.sv]
module gcsp_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  gcsp_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output gcsp_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    gcsp_pkg::item_t item_reg;

    // The register may refill in the same cycle its beat moves on.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/gcsp_core.sv]
module gcsp_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  gcsp_pkg::item_t                   item,
    input  logic                              cfg_we,
    input  logic [gcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data,
    output gcsp_pkg::result_t                 result
);

    logic [31:0] status_reg,      status_next;
    logic [3:0]  rem_reg,         rem_next;
    logic [3:0]  pos_reg,         pos_next;
    logic [31:0] info_reg,        info_next;
    logic [9:0]  start_x_reg,     start_x_next;
    logic [9:0]  start_y_reg,     start_y_next;
    logic [9:0]  draw_left_reg,   draw_left_next;
    logic [8:0]  draw_top_reg,    draw_top_next;
    logic [10:0] draw_right_reg,  draw_right_next;
    logic [9:0]  draw_bottom_reg, draw_bottom_next;
    logic [10:0] offset_x_reg,    offset_x_next;
    logic [10:0] offset_y_reg,    offset_y_next;

    logic [7:0]  op;
    logic [10:0] right_m1;
    logic [9:0]  bottom_m1;
    logic [31:0] info_val;

    assign op        = item.word[31:24];
    assign right_m1  = draw_right_reg - 11'd1;
    assign bottom_m1 = draw_bottom_reg - 10'd1;

    // Info query result for the current control word.
    always_comb begin
        case (item.word[15:0]) inside
            gcsp_pkg::INFO_AREA_A, gcsp_pkg::INFO_AREA_B, gcsp_pkg::INFO_AREA_C: begin
                info_val = {13'd0, draw_top_reg, draw_left_reg};
            end
            gcsp_pkg::INFO_AREA_END: begin
                info_val = {12'd0, bottom_m1, right_m1[9:0]};
            end
            gcsp_pkg::INFO_OFFS_A, gcsp_pkg::INFO_OFFS_B: begin
                info_val = {10'd0, offset_y_reg, offset_x_reg};
            end
            gcsp_pkg::INFO_VERSION: info_val = gcsp_pkg::INFO_VERSION_VAL;
            default:                info_val = 32'd0;
        endcase
    end

    // Next state and result for one item, plus configuration writes.
    always_comb begin
        status_next      = status_reg;
        rem_next         = rem_reg;
        pos_next         = pos_reg;
        info_next        = info_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        draw_left_next   = draw_left_reg;
        draw_top_next    = draw_top_reg;
        draw_right_next  = draw_right_reg;
        draw_bottom_next = draw_bottom_reg;
        offset_x_next    = offset_x_reg;
        offset_y_next    = offset_y_reg;
        result           = '0;

        if (cfg_we) begin
            unique case (cfg_index)
                gcsp_pkg::CFG_DRAW_LEFT:   draw_left_next   = cfg_data[9:0];
                gcsp_pkg::CFG_DRAW_TOP:    draw_top_next    = cfg_data[8:0];
                gcsp_pkg::CFG_DRAW_RIGHT:  draw_right_next  = cfg_data[10:0];
                gcsp_pkg::CFG_DRAW_BOTTOM: draw_bottom_next = cfg_data[9:0];
                gcsp_pkg::CFG_OFFSET_X:    offset_x_next    = cfg_data[10:0];
                gcsp_pkg::CFG_OFFSET_Y:    offset_y_next    = cfg_data[10:0];
                default: ;
            endcase
        end

        if (step) begin
            unique case (item.cmd)
                gcsp_pkg::CMD_DATA_WR: begin
                    status_next = status_reg | gcsp_pkg::ST_IDLE_BITS;
                    if (rem_reg != 4'd0) begin
                        rem_next           = rem_reg - 4'd1;
                        result.packet_slot = pos_reg;
                        pos_next           = pos_reg + 4'd1;
                    end else begin
                        rem_next = gcsp_pkg::word_count(op);
                        pos_next = 4'd1;
                    end
                    result.packet_word  = item.word;
                    result.packet_valid = 1'b1;
                    result.packet_done  = (rem_next == 4'd0);
                end
                gcsp_pkg::CMD_CTRL_WR: begin
                    unique case (op) inside
                        gcsp_pkg::CTL_RESET: begin
                            status_next      = gcsp_pkg::ST_RESET;
                            draw_right_next  = gcsp_pkg::DRAW_RIGHT_RST;
                            draw_bottom_next = gcsp_pkg::DRAW_BOTTOM_RST;
                        end
                        gcsp_pkg::CTL_ABORT_A, gcsp_pkg::CTL_ABORT_B: begin
                            status_next = status_reg & ~gcsp_pkg::ST_DMA_READY;
                            rem_next    = 4'd0;
                        end
                        gcsp_pkg::CTL_DISP_EN: begin
                            status_next = (status_reg & ~gcsp_pkg::ST_DISP_OFF)
                                        | {8'd0, item.word[0], 23'd0};
                        end
                        gcsp_pkg::CTL_DMA_DIR: begin
                            if (item.word == gcsp_pkg::DMA_OFF_WORD) begin
                                rem_next = 4'd0;
                            end
                            status_next = (status_reg & ~gcsp_pkg::ST_DMA_DIR)
                                        | {1'b0, item.word[1:0], 29'd0};
                        end
                        gcsp_pkg::CTL_DISP_START: begin
                            start_x_next = item.word[9:0];
                            start_y_next = item.word[19:10];
                        end
                        gcsp_pkg::CTL_MODE: begin
                            status_next = (status_reg & ~gcsp_pkg::ST_MODE_MASK)
                                        | {9'd0, item.word[5:0], item.word[6], 16'd0};
                        end
                        gcsp_pkg::CTL_INFO: info_next = info_val;
                        // Range, bus and unlisted opcodes do not reach any output.
                        default: ;
                    endcase
                end
                gcsp_pkg::CMD_STATUS_RD: result.read_value = status_reg;
                gcsp_pkg::CMD_DATA_RD: begin
                    status_next       = status_reg | gcsp_pkg::ST_IDLE_BITS;
                    result.read_value = info_reg;
                end
                gcsp_pkg::CMD_VBLANK: status_next = status_reg ^ gcsp_pkg::ST_FIELD;
                default: ;
            endcase
        end

        // Display geometry as it stands after this item.
        result.display_x      = start_x_next;
        result.display_y      = start_y_next;
        result.display_width  = gcsp_pkg::width_lut(status_next[18:16]);
        result.display_height = gcsp_pkg::height_lut(status_next[20:19]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= gcsp_pkg::ST_RESET;
            rem_reg         <= 4'd0;
            pos_reg         <= 4'd0;
            info_reg        <= 32'd0;
            start_x_reg     <= 10'd0;
            start_y_reg     <= 10'd0;
            draw_left_reg   <= 10'd0;
            draw_top_reg    <= 9'd0;
            draw_right_reg  <= gcsp_pkg::DRAW_RIGHT_RST;
            draw_bottom_reg <= gcsp_pkg::DRAW_BOTTOM_RST;
            offset_x_reg    <= 11'd0;
            offset_y_reg    <= 11'd0;
        end else begin
            status_reg      <= status_next;
            rem_reg         <= rem_next;
            pos_reg         <= pos_next;
            info_reg        <= info_next;
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
            draw_left_reg   <= draw_left_next;
            draw_top_reg    <= draw_top_next;
            draw_right_reg  <= draw_right_next;
            draw_bottom_reg <= draw_bottom_next;
            offset_x_reg    <= offset_x_next;
            offset_y_reg    <= offset_y_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A header always leaves the framer pointing at slot one.
    a_header_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.cmd == gcsp_pkg::CMD_DATA_WR && rem_reg == 4'd0 |=> pos_reg == 4'd1)
        else $error("packet position not reset by header");

    // A status read has no side effect on the status word.
    a_status_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.cmd == gcsp_pkg::CMD_STATUS_RD && !cfg_we |=> $stable(status_reg))
        else $error("status read changed status");

    // No packet can be open without a header having been seen.
    a_pos_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == 4'd0 |-> rem_reg == 4'd0)
        else $error("packet words pending with no header");
`endif

endmodule

[rtl/gcsp_out_stage.sv]
module gcsp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  gcsp_pkg::result_t result,
    output logic              take,
    input  logic              item_valid,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gcsp_pkg::result_t m_result
);

    logic              valid_reg;
    logic              valid_next;
    gcsp_pkg::result_t result_reg;

    // A new result loads whenever the register is empty or being drained.
    assign take       = item_valid && (!valid_reg || m_tready);
    assign valid_next = take ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

`ifndef NO_ASSERTIONS
    // Only packet beats can close a packet.
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && result_reg.packet_done |-> result_reg.packet_valid)
        else $error("packet done without packet word");
`endif

endmodule

[rtl/gpu_command_and_status_port.sv]
// Path: an accepted input beat passes the input register, then the result register, before
// its result beat is offered on m_tvalid.
// Throughput: one item per cycle while m_tready is high; single-pass decode and table
// lookup between the registers. Configuration writes never stall; cfg_ready is always high.
// Reset: synchronous active-low aresetn empties both registers and restores all
// display state and drawing bounds to their power-on values.
module gpu_command_and_status_port (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // word
    input  logic [2:0]                     s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value, packet_word, packet_slot, display_x, display_y,
    // display_width, display_height, zero fill
    output logic [111:0]                   m_tdata,
    output logic [0:0]                     m_tuser,   // packet_valid
    output logic                           m_tlast,   // packet_done
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gcsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    gcsp_pkg::item_t   s_item;
    gcsp_pkg::item_t   item;
    gcsp_pkg::result_t result;
    gcsp_pkg::result_t m_result;
    logic              item_valid;
    logic              take;

    assign s_item.cmd  = gcsp_pkg::cmd_t'(s_tuser);
    assign s_item.word = s_tdata;
    assign cfg_ready   = 1'b1;

    gcsp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    gcsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    gcsp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .result     (result),
        .take       (take),
        .item_valid (item_valid),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_tdata = {5'd0, m_result.display_height, m_result.display_width,
                      m_result.display_y, m_result.display_x, m_result.packet_slot,
                      m_result.packet_word, m_result.read_value};
    assign m_tuser = m_result.packet_valid;
    assign m_tlast = m_result.packet_done;

endmodule
